>>> sv/line_break_point_finder_macros.svh
// assertion macros used by the line break point finder
`ifndef LINE_BREAK_POINT_FINDER_MACROS_SVH
`define LINE_BREAK_POINT_FINDER_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define LBPF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every clock edge, reset included
`define LBPF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LBPF_ASSERT(label, clk, rst, prop, msg)

`define LBPF_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> sv/lbpf_pkg.sv
package lbpf_pkg;

   localparam int PosW      = 16;
   localparam int CodeW     = 16;
   localparam int LenW      = 3;
   localparam int CsrIndexW = 1;

   // register indexes on the csr port
   localparam logic [CsrIndexW-1:0] CSR_MIN_BREAK = 1'b0;
   localparam logic [CsrIndexW-1:0] CSR_MAX_SCAN  = 1'b1;

   localparam logic [PosW-1:0] PosMax        = 16'hFFFF;
   localparam logic [PosW-1:0] MaxScanReset  = 16'd80;
   localparam logic [PosW-1:0] MinBreakReset = 16'd0;

   localparam logic [CodeW-1:0] LatinTop   = 16'h0100;
   localparam logic [CodeW-1:0] SpaceLo    = 16'h2000;
   localparam logic [CodeW-1:0] SpaceHi    = 16'h200B;
   localparam logic [CodeW-1:0] LineSep    = 16'h2028;
   localparam logic [CodeW-1:0] ParaSep    = 16'h2029;
   localparam logic [CodeW-1:0] IdeoSpace  = 16'h3000;

   localparam int PunctCount = 226;

   localparam logic [CodeW-1:0] PUNCT_TAB [PunctCount] = '{
      16'h0374, 16'h0375, 16'h037e, 16'h0387, 16'h055a, 16'h055b, 16'h055c,
      16'h055d, 16'h055e, 16'h055f, 16'h0589, 16'h05be, 16'h05c0, 16'h05c3, 16'h05f3,
      16'h05f4,
      16'h060c, 16'h061b, 16'h061f, 16'h066a, 16'h066b, 16'h066c, 16'h066d, 16'h06d4,
      16'h0964,
      16'h0965, 16'h0970, 16'h0e2f, 16'h0e5a, 16'h0e5b, 16'h0eaf, 16'h0f04, 16'h0f05,
      16'h0f06,
      16'h0f07, 16'h0f08, 16'h0f09, 16'h0f0a, 16'h0f0b, 16'h0f0c, 16'h0f0d, 16'h0f0e,
      16'h0f0f,
      16'h0f10, 16'h0f11, 16'h0f12, 16'h0f3a, 16'h0f3b, 16'h0f3c, 16'h0f3d, 16'h0f85,
      16'h10fb,
      16'h2000, 16'h2001, 16'h2002, 16'h2003, 16'h2004, 16'h2005, 16'h2006, 16'h2007,
      16'h2008, 16'h2009, 16'h200a, 16'h200b, 16'h2010, 16'h2011, 16'h2012, 16'h2013,
      16'h2014, 16'h2015, 16'h2016, 16'h2017, 16'h2018, 16'h2019, 16'h201a, 16'h201b,
      16'h201c, 16'h201d, 16'h201e, 16'h201f, 16'h2020, 16'h2021, 16'h2022, 16'h2023,
      16'h2024, 16'h2025, 16'h2026, 16'h2027, 16'h2028, 16'h2029, 16'h2030, 16'h2031,
      16'h2032, 16'h2033, 16'h2034, 16'h2035, 16'h2036, 16'h2037, 16'h2038, 16'h2039,
      16'h203a, 16'h203b, 16'h203c, 16'h203d, 16'h203e, 16'h203f, 16'h2040, 16'h2041,
      16'h2042, 16'h2043, 16'h2045, 16'h2046, 16'h207d, 16'h207e, 16'h208d, 16'h208e,
      16'h2329, 16'h232a, 16'h3000, 16'h3001, 16'h3002, 16'h3003, 16'h3006, 16'h3008,
      16'h3009, 16'h300a, 16'h300b, 16'h300c, 16'h300d, 16'h300e, 16'h300f, 16'h3010,
      16'h3011, 16'h3014, 16'h3015, 16'h3016, 16'h3017, 16'h3018, 16'h3019, 16'h301a,
      16'h301b, 16'h301c, 16'h301d, 16'h301e, 16'h301f, 16'h3030, 16'h30fb, 16'hfd3e,
      16'hfd3f, 16'hfe30, 16'hfe31, 16'hfe32, 16'hfe33, 16'hfe34, 16'hfe35, 16'hfe36,
      16'hfe37, 16'hfe38, 16'hfe39, 16'hfe3a, 16'hfe3b, 16'hfe3c, 16'hfe3d, 16'hfe3e,
      16'hfe3f, 16'hfe40, 16'hfe41, 16'hfe42, 16'hfe43, 16'hfe44, 16'hfe49, 16'hfe4a,
      16'hfe4b, 16'hfe4c, 16'hfe4d, 16'hfe4e, 16'hfe4f, 16'hfe50, 16'hfe51, 16'hfe52,
      16'hfe54, 16'hfe55, 16'hfe56, 16'hfe57, 16'hfe58, 16'hfe59, 16'hfe5a, 16'hfe5b,
      16'hfe5c, 16'hfe5d, 16'hfe5e, 16'hfe5f, 16'hfe60, 16'hfe61, 16'hfe63, 16'hfe68,
      16'hfe6a, 16'hfe6b, 16'hff01, 16'hff02, 16'hff03, 16'hff05, 16'hff06, 16'hff07,
      16'hff08, 16'hff09, 16'hff0a, 16'hff0c, 16'hff0d, 16'hff0e, 16'hff0f, 16'hff1a,
      16'hff1b, 16'hff1f, 16'hff20, 16'hff3b, 16'hff3c, 16'hff3d, 16'hff3f, 16'hff5b,
      16'hff5d, 16'hff61, 16'hff62, 16'hff63, 16'hff64, 16'hff65};

   typedef struct packed {
      logic [CodeW-1:0] char_code;
      logic [LenW-1:0]  char_len;
      logic             end_of_text;
   } req_type;

   typedef struct packed {
      logic [PosW-1:0] break_offset;
      logic            at_delimiter;
      logic            no_position;
   } rsp_type;

   typedef struct packed {
      logic [PosW-1:0] min_break;
      logic [PosW-1:0] max_scan;
   } cfg_type;

   // what the scan core decides for the word in the input register
   typedef struct packed {
      logic    emit;
      rsp_type rsp;
   } step_type;

   function automatic logic [PosW-1:0] sat_add(input logic [PosW-1:0] a,
                                               input logic [PosW-1:0] b);
      logic [PosW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[PosW] ? PosMax : sum[PosW-1:0];
   endfunction

endpackage

>>> sv/lbpf_classify.sv
module lbpf_classify (
   input  logic [lbpf_pkg::CodeW-1:0] char_code,
   output logic                       is_delim
);

   logic alnum;
   logic in_tab;

   always_comb begin
      alnum = (char_code >= 16'h0030 && char_code <= 16'h0039)
           || (char_code >= 16'h0041 && char_code <= 16'h005A)
           || (char_code >= 16'h0061 && char_code <= 16'h007A);
   end

   // parallel compare against the punctuation table
   always_comb begin
      in_tab = 1'b0;
      for (int k = 0; k < lbpf_pkg::PunctCount; k++) begin
         if (lbpf_pkg::PUNCT_TAB[k] == char_code) begin
            in_tab = 1'b1;
         end
      end
   end

   always_comb begin
      if (char_code < lbpf_pkg::LatinTop) begin
         is_delim = !alnum;
      end else begin
         is_delim = (char_code >= lbpf_pkg::SpaceLo && char_code <= lbpf_pkg::SpaceHi)
                 || char_code == lbpf_pkg::LineSep
                 || char_code == lbpf_pkg::ParaSep
                 || char_code == lbpf_pkg::IdeoSpace
                 || in_tab;
      end
   end

endmodule

>>> sv/lbpf_core.sv
module lbpf_core (
   input  logic               clock,
   input  logic               reset,
   input  lbpf_pkg::cfg_type  cfg,
   input  lbpf_pkg::req_type  item,
   input  logic               is_delim,
   input  logic               step_en,
   output lbpf_pkg::step_type step
);

   logic [lbpf_pkg::PosW-1:0] byte_pos_ff, byte_pos_in;
   logic [lbpf_pkg::PosW-1:0] mark_pos_ff, mark_pos_in;
   logic                      mark_valid_ff, mark_valid_in;
   logic [lbpf_pkg::PosW-1:0] safe_pos_ff, safe_pos_in;
   logic                      safe_valid_ff, safe_valid_in;
   logic                      scan_done_ff, scan_done_in;

   // state after this word, before an end of text clears it
   logic [lbpf_pkg::PosW-1:0] v_byte_pos, v_mark_pos, v_safe_pos;
   logic                      v_mark_valid, v_safe_valid, v_scan_done;
   logic [lbpf_pkg::PosW-1:0] next_pos, pos_plus_one;
   logic                      emit;

   always_comb begin
      next_pos     = lbpf_pkg::sat_add(byte_pos_ff,
                        {{(lbpf_pkg::PosW-lbpf_pkg::LenW){1'b0}}, item.char_len});
      pos_plus_one = lbpf_pkg::sat_add(byte_pos_ff, 16'd1);

      v_byte_pos   = byte_pos_ff;
      v_mark_pos   = mark_pos_ff;
      v_mark_valid = mark_valid_ff;
      v_safe_pos   = safe_pos_ff;
      v_safe_valid = safe_valid_ff;
      v_scan_done  = scan_done_ff;
      emit         = 1'b0;

      priority if (scan_done_ff) begin
         // waiting for end of text after an early end
      end else if (item.end_of_text) begin
         emit = 1'b1;
      end else if (byte_pos_ff >= cfg.max_scan) begin
         emit        = 1'b1;
         v_scan_done = 1'b1;
      end else if (item.char_len == '0) begin
         v_safe_pos   = pos_plus_one;
         v_safe_valid = 1'b1;
         emit         = 1'b1;
         v_scan_done  = 1'b1;
      end else begin
         v_safe_pos   = byte_pos_ff;
         v_safe_valid = 1'b1;
         v_byte_pos   = next_pos;
         if (is_delim) begin
            v_mark_pos   = next_pos;
            v_mark_valid = 1'b1;
         end
         if (next_pos >= cfg.max_scan) begin
            emit        = 1'b1;
            v_scan_done = 1'b1;
         end
      end
   end

   always_comb begin
      step.emit = emit;
      if (v_mark_valid && v_mark_pos > cfg.min_break) begin
         step.rsp.break_offset = v_mark_pos;
         step.rsp.at_delimiter = 1'b1;
         step.rsp.no_position  = 1'b0;
      end else if (v_safe_valid) begin
         step.rsp.break_offset = v_safe_pos;
         step.rsp.at_delimiter = 1'b0;
         step.rsp.no_position  = 1'b0;
      end else begin
         step.rsp.break_offset = '0;
         step.rsp.at_delimiter = 1'b0;
         step.rsp.no_position  = 1'b1;
      end
   end

   always_comb begin
      if (item.end_of_text) begin
         byte_pos_in   = '0;
         mark_pos_in   = '0;
         mark_valid_in = 1'b0;
         safe_pos_in   = '0;
         safe_valid_in = 1'b0;
         scan_done_in  = 1'b0;
      end else begin
         byte_pos_in   = v_byte_pos;
         mark_pos_in   = v_mark_pos;
         mark_valid_in = v_mark_valid;
         safe_pos_in   = v_safe_pos;
         safe_valid_in = v_safe_valid;
         scan_done_in  = v_scan_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff   <= '0;
         mark_pos_ff   <= '0;
         mark_valid_ff <= 1'b0;
         safe_pos_ff   <= '0;
         safe_valid_ff <= 1'b0;
         scan_done_ff  <= 1'b0;
      end else if (step_en) begin
         byte_pos_ff   <= byte_pos_in;
         mark_pos_ff   <= mark_pos_in;
         mark_valid_ff <= mark_valid_in;
         safe_pos_ff   <= safe_pos_in;
         safe_valid_ff <= safe_valid_in;
         scan_done_ff  <= scan_done_in;
      end
   end

endmodule

>>> sv/line_break_point_finder.sv
// Line break point finder: takes one decoded character per word (code, byte
// length, end-of-text flag) and returns at most one result per line, the byte
// offset at which to break it. The result comes when the scan ends: at end of
// text, at a character of invalid length, or when the byte position reaches
// max_scan; after an early end, words are swallowed until end of text. The
// block sustains one word per cycle unless a word with a result meets an
// untaken result in rsp_. A word is held in the input register, where
// delimiter lookup (a parallel compare against the punctuation table) and the
// saturating position add run; when the word moves on, its result, if any,
// is loaded into the result register, which drives rsp_valid. The input
// register keeps loading while rsp_ holds an untaken result, as long as the
// word in it produces none. csr_ready is always high; csr writes belong between lines, when no word is in flight.
`include "line_break_point_finder_macros.svh"

module line_break_point_finder (
   input  logic                            clock,
   input  logic                            reset,
   // character words in
   input  logic                            req_valid,
   output logic                            req_ready,
   input  lbpf_pkg::req_type               req_data,
   // break results out
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output lbpf_pkg::rsp_type               rsp_data,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lbpf_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [lbpf_pkg::PosW-1:0]       csr_wdata
);

   // configuration registers
   logic [lbpf_pkg::PosW-1:0] min_break_ff;
   logic [lbpf_pkg::PosW-1:0] max_scan_ff;
   lbpf_pkg::cfg_type         cfg;

   // input register
   logic                      in_valid_ff, in_valid_in;
   lbpf_pkg::req_type         in_data_ff;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   lbpf_pkg::rsp_type         rsp_data_ff;

   logic                      is_delim;
   lbpf_pkg::step_type        step;
   logic                      advance;
   logic                      req_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_break_ff <= lbpf_pkg::MinBreakReset;
         max_scan_ff  <= lbpf_pkg::MaxScanReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            lbpf_pkg::CSR_MIN_BREAK: min_break_ff <= csr_wdata;
            lbpf_pkg::CSR_MAX_SCAN:  max_scan_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg.min_break = min_break_ff;
   assign cfg.max_scan  = max_scan_ff;

   lbpf_classify u_classify (
      .char_code (in_data_ff.char_code),
      .is_delim  (is_delim)
   );

   lbpf_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .item     (in_data_ff),
      .is_delim (is_delim),
      .step_en  (advance),
      .step     (step)
   );

   // the held word moves on unless it has a result and the result slot is stuck
   assign advance   = in_valid_ff && (!step.emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   end

   always_comb begin
      if (advance && step.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance && step.emit) begin
         rsp_data_ff <= step.rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a finished word with a result always lands in the result slot
   `LBPF_ASSERT(a_emit_lands, clock, reset, (advance && step.emit) |=> rsp_valid_ff,
                "result lost")
   // an untaken result holds its value
   `LBPF_ASSERT(a_rsp_holds, clock, reset,
                (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)),
                "result changed while stalled")
   // no-position results carry zero offset and no delimiter flag
   `LBPF_ASSERT(a_no_pos_zero, clock, reset,
                (rsp_valid_ff && rsp_data_ff.no_position) |->
                (rsp_data_ff.break_offset == '0 && !rsp_data_ff.at_delimiter),
                "bad no-position result")
   // an accepted word is held in the input register next cycle
   `LBPF_ASSERT(a_take_loads, clock, reset, req_take |=> in_valid_ff, "accepted word dropped")

endmodule

>>> dv/line_break_point_finder_checker.sv
`timescale 1ns / 100ps

// watches the three channels of the line break point finder, keeps its own
// model of the scan and compares every break result with the oldest one due
module line_break_point_finder_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  lbpf_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  lbpf_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [lbpf_pkg::CsrIndexW-1:0] csr_index,
   input  logic [lbpf_pkg::PosW-1:0]      csr_wdata,
   output int                             fail_count,
   output int                             outstanding,
   output int                             breaks_checked
);

   import lbpf_pkg::*;

   localparam logic [15:0] MinBreakAtReset = 16'd0;
   localparam logic [15:0] MaxScanAtReset  = 16'd80;

   // shadow registers
   logic [15:0] min_break_cfg;
   logic [15:0] max_scan_cfg;

   // scan state of the current line
   logic [15:0] line_pos;
   logic [15:0] delim_end;
   bit          delim_seen;
   logic [15:0] char_start;
   bit          start_seen;
   bit          swallowing;

   rsp_type breaks_due[$];
   int      errors;
   int      checked;

   function automatic logic [15:0] add_clamped(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

   function automatic bit in_span(input logic [15:0] c, input logic [15:0] lo,
                                  input logic [15:0] hi);
      return c >= lo && c <= hi;
   endfunction

   // fixed whitespace codes fall inside the punctuation spans below
   function automatic bit is_delimiter(input logic [15:0] c);
      if (c < 16'h0100)
         return !(in_span(c, 16'h0030, 16'h0039) || in_span(c, 16'h0041, 16'h005a) ||
                  in_span(c, 16'h0061, 16'h007a));
      return in_span(c, 16'h0374, 16'h0375) || c == 16'h037e || c == 16'h0387 ||
             in_span(c, 16'h055a, 16'h055f) || c == 16'h0589 || c == 16'h05be ||
             c == 16'h05c0 || c == 16'h05c3 || in_span(c, 16'h05f3, 16'h05f4) ||
             c == 16'h060c || c == 16'h061b || c == 16'h061f ||
             in_span(c, 16'h066a, 16'h066d) || c == 16'h06d4 ||
             in_span(c, 16'h0964, 16'h0965) || c == 16'h0970 || c == 16'h0e2f ||
             in_span(c, 16'h0e5a, 16'h0e5b) || c == 16'h0eaf ||
             in_span(c, 16'h0f04, 16'h0f12) || in_span(c, 16'h0f3a, 16'h0f3d) ||
             c == 16'h0f85 || c == 16'h10fb ||
             in_span(c, 16'h2000, 16'h200b) || in_span(c, 16'h2010, 16'h2029) ||
             in_span(c, 16'h2030, 16'h2043) || in_span(c, 16'h2045, 16'h2046) ||
             in_span(c, 16'h207d, 16'h207e) || in_span(c, 16'h208d, 16'h208e) ||
             in_span(c, 16'h2329, 16'h232a) || in_span(c, 16'h3000, 16'h3003) ||
             c == 16'h3006 || in_span(c, 16'h3008, 16'h3011) ||
             in_span(c, 16'h3014, 16'h301f) || c == 16'h3030 || c == 16'h30fb ||
             in_span(c, 16'hfd3e, 16'hfd3f) || in_span(c, 16'hfe30, 16'hfe44) ||
             in_span(c, 16'hfe49, 16'hfe52) || in_span(c, 16'hfe54, 16'hfe61) ||
             c == 16'hfe63 || c == 16'hfe68 || in_span(c, 16'hfe6a, 16'hfe6b) ||
             in_span(c, 16'hff01, 16'hff03) || in_span(c, 16'hff05, 16'hff0a) ||
             in_span(c, 16'hff0c, 16'hff0f) || in_span(c, 16'hff1a, 16'hff1b) ||
             in_span(c, 16'hff1f, 16'hff20) || in_span(c, 16'hff3b, 16'hff3d) ||
             c == 16'hff3f || c == 16'hff5b || c == 16'hff5d ||
             in_span(c, 16'hff61, 16'hff65);
   endfunction

   function automatic void start_new_line();
      line_pos   = '0;
      delim_end  = '0;
      delim_seen = 1'b0;
      char_start = '0;
      start_seen = 1'b0;
      swallowing = 1'b0;
   endfunction

   function automatic rsp_type chosen_break();
      rsp_type r;
      r = '0;
      if (delim_seen && delim_end > min_break_cfg) begin
         r.break_offset = delim_end;
         r.at_delimiter = 1'b1;
      end else if (start_seen) begin
         r.break_offset = char_start;
      end else begin
         r.no_position = 1'b1;
      end
      return r;
   endfunction

   function automatic void predict_word(input req_type w);
      if (swallowing) begin
         if (w.end_of_text) start_new_line();
         return;
      end
      if (w.end_of_text) begin
         breaks_due.push_back(chosen_break());
         start_new_line();
         return;
      end
      // limit passed before this character, it is not consumed
      if (line_pos >= max_scan_cfg) begin
         breaks_due.push_back(chosen_break());
         swallowing = 1'b1;
         return;
      end
      char_start = line_pos;
      start_seen = 1'b1;
      if (w.char_len == 3'd0) begin
         char_start = add_clamped(line_pos, 16'd1);
         breaks_due.push_back(chosen_break());
         swallowing = 1'b1;
         return;
      end
      line_pos = add_clamped(line_pos, {13'd0, w.char_len});
      if (is_delimiter(w.char_code)) begin
         delim_end  = line_pos;
         delim_seen = 1'b1;
      end
      if (line_pos >= max_scan_cfg) begin
         breaks_due.push_back(chosen_break());
         swallowing = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         min_break_cfg = MinBreakAtReset;
         max_scan_cfg  = MaxScanAtReset;
         start_new_line();
         breaks_due.delete();
         errors  = 0;
         checked = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIN_BREAK: min_break_cfg = csr_wdata;
               CSR_MAX_SCAN:  max_scan_cfg  = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (breaks_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected break result offset=%0d delim=%0d none=%0d",
                        $time, rsp_data.break_offset, rsp_data.at_delimiter,
                        rsp_data.no_position);
            end else begin
               want = breaks_due.pop_front();
               checked++;
               if (rsp_data.break_offset !== want.break_offset ||
                   rsp_data.at_delimiter !== want.at_delimiter ||
                   rsp_data.no_position !== want.no_position) begin
                  errors++;
                  $display({"%0t: break mismatch, expected offset=%0d delim=%0d none=%0d,",
                            " got offset=%0d delim=%0d none=%0d"}, $time,
                           want.break_offset, want.at_delimiter, want.no_position,
                           rsp_data.break_offset, rsp_data.at_delimiter,
                           rsp_data.no_position);
               end
            end
         end
         if (req_valid && req_ready) predict_word(req_data);
      end
      fail_count     <= errors;
      outstanding    <= breaks_due.size();
      breaks_checked <= checked;
   end

endmodule

>>> dv/tb_line_break_point_finder.sv
`timescale 1ns / 100ps

module tb_line_break_point_finder;

   import lbpf_pkg::*;

   localparam int RandomWords  = 1750;
   localparam int ConfigGroups = 4;     // register settings per idling phase
   localparam int DrainCycles  = 4;     // drain margin after the last result
   localparam int HoldCycles   = 300;   // long receiver hold-off
   localparam int StallLimit   = 3000;  // cycles with no handshake at all

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CsrIndexW-1:0] csr_index;
   logic [PosW-1:0]      csr_wdata;

   int fail_count;
   int outstanding;
   int breaks_checked;

   // idling knobs, percent of cycles
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // long hold-off handshake between stimulus and receiver
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;

   int words_sent = 0;
   int lines_sent = 0;
   int reg_writes = 0;
   int stall_cycles = 0;

   line_break_point_finder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   line_break_point_finder_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .breaks_checked (breaks_checked)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // receiver: random back-pressure, or a long hold when the stimulus asks
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left    <= HoldCycles;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: any handshake restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("%0t: no handshake for %0d cycles", $time, StallLimit);
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // one character word; valid stays up until the word is taken
   task automatic send_word(input logic [15:0] code, input logic [2:0] len, input bit eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{char_code: code, char_len: len, end_of_text: eot};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // terminating word, code and length are don't-care so they get random bits
   task automatic end_line();
      send_word(16'($urandom), 3'($urandom), 1'b1);
      lines_sent++;
   endtask

   // sender pauses until every break result is back and the pipe is empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // both registers, back to back on the csr channel, only when idle
   task automatic program_regs(input logic [15:0] min_b, input logic [15:0] max_s);
      settle();
      csr_valid <= 1'b1;
      csr_index <= CSR_MIN_BREAK;
      csr_wdata <= min_b;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_MAX_SCAN;
      csr_wdata <= max_s;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      reg_writes += 2;
   endtask

   // character mix: plain letters and digits, low codes, table punctuation,
   // whitespace, codes just beside the table spans, and anything at all
   function automatic logic [15:0] pick_code();
      int sel;
      int k;
      logic [15:0] c;
      sel = $urandom_range(99);
      if (sel < 35) begin
         k = $urandom_range(61);
         if (k < 10)      c = 16'(k + 'h30);
         else if (k < 36) c = 16'(k - 10 + 'h41);
         else             c = 16'(k - 36 + 'h61);
      end else if (sel < 50) begin
         c = 16'($urandom_range(255));
      end else if (sel < 62) begin
         c = PUNCT_TAB[$urandom_range(PunctCount - 1)];
      end else if (sel < 68) begin
         c = 16'(16'h2000 + $urandom_range(11));
      end else if (sel < 80) begin
         case ($urandom_range(15))
            0:       c = 16'h0100;
            1:       c = 16'h00ff;
            2:       c = 16'h200c;
            3:       c = 16'h2044;
            4:       c = 16'h3007;
            5:       c = 16'hfe53;
            6:       c = 16'hff00;
            7:       c = 16'hff66;
            8:       c = 16'hffff;
            9:       c = 16'h2028;
            10:      c = 16'h2029;
            11:      c = 16'h3000;
            12:      c = 16'h0373;
            13:      c = 16'h10fc;
            14:      c = 16'h0000;
            default: c = 16'h007f;
         endcase
      end else begin
         c = 16'($urandom);
      end
      return c;
   endfunction

   // mostly 1..4 bytes, a few oversized, a few invalid
   function automatic logic [2:0] pick_len();
      int sel;
      sel = $urandom_range(99);
      if (sel < 3) return 3'd0;
      if (sel < 8) return 3'($urandom_range(7, 5));
      return 3'($urandom_range(4, 1));
   endfunction

   task automatic send_line(input int n_chars);
      repeat (n_chars) send_word(pick_code(), pick_len(), 1'b0);
      end_line();
   endtask

   // register setting for each group; extremes come round twice
   task automatic program_group(input int g);
      case (g % 6)
         0: program_regs(16'd0, 16'd80);
         1: program_regs(16'd0, 16'd0);
         2: program_regs(16'hffff, 16'hffff);
         3: program_regs(16'($urandom_range(20)), 16'($urandom_range(40, 1)));
         4: program_regs(16'($urandom), 16'($urandom_range(120)));
         default: program_regs(16'd2, 16'd6);
      endcase
   endtask

   initial begin
      int quota;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_MIN_BREAK;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed lines, registers at their reset values ----
      // empty text: no position at all
      end_line();
      // digits and letters only: break at the start of the last character
      send_word(16'h0030, 3'd1, 1'b0);
      send_word(16'h007a, 3'd2, 1'b0);
      end_line();
      // ascii punctuation then a letter: break after the delimiter
      send_word(16'h002f, 3'd1, 1'b0);
      send_word(16'h005a, 3'd1, 1'b0);
      end_line();
      // above latin-1: plain code, last table entry, top code
      send_word(16'h0100, 3'd3, 1'b0);
      send_word(16'hff65, 3'd3, 1'b0);
      send_word(16'hffff, 3'd4, 1'b0);
      end_line();
      // invalid length ends early, following words are swallowed
      send_word(16'h0061, 3'd1, 1'b0);
      send_word(16'hffff, 3'd0, 1'b0);
      send_word(16'h2000, 3'd1, 1'b0);
      end_line();
      // scan limit lowered below the position in the middle of a line
      send_word(16'h0062, 3'd7, 1'b0);
      send_word(16'h0374, 3'd7, 1'b0);
      program_regs(16'd20, 16'd10);
      send_word(16'h3000, 3'd1, 1'b0);
      end_line();
      // zero scan limit: the first character stops the scan with nothing seen
      program_regs(16'd0, 16'd0);
      send_word(16'h0071, 3'd4, 1'b0);
      end_line();
      // limit hit exactly by an oversized delimiter, min break at its top
      program_regs(16'hffff, 16'd5);
      send_word(16'h2029, 3'd5, 1'b0);
      end_line();

      // ---- random lines under three idling mixes ----
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 28;
               recv_idle_pct <= 87;
            end
            1: begin
               send_idle_pct = 87;
               recv_idle_pct <= 28;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase
         for (int k = 0; k < ConfigGroups; k++) begin
            program_group(phase * ConfigGroups + k);
            quota = words_sent + RandomWords / (3 * ConfigGroups);
            while (words_sent < quota) begin
               if ($urandom_range(99) < 80) send_line($urandom_range(12));
               else                          send_line($urandom_range(40));
            end
         end
      end

      // receiver holds off while short lines keep coming, so the block backs up
      program_regs(16'd0, 16'd3);
      hold_requests <= hold_requests + 1;
      repeat (40) send_line($urandom_range(2));

      settle();
      $display("run covered %0d words in %0d lines, %0d break results checked, %0d reg writes",
               words_sent, lines_sent, breaks_checked, reg_writes);
      $display("with sender-heavy, receiver-heavy and no idling, and a long receiver hold");
      if (fail_count == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
